/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the complex ALU.
// Implication forms, same cycle and next cycle; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CNA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CNA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CNA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CNA_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

/* hdl/cna_pkg.sv */
// Package of the complex ALU: widths, operation codes, transaction types
// and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package cna_pkg;
  localparam int DW   = 16;
  localparam int FB   = 8;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int QW   = DW + 1;
  localparam int NW   = PW;
  localparam int RW   = NW + FB;
  localparam int CW   = NW + QW;
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;
  localparam int RQ_DEPTH = 32;
  localparam int RQ_AW    = 5;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic signed [DW-1:0] a_r;
    logic signed [DW-1:0] a_i;
    logic signed [DW-1:0] b_r;
    logic signed [DW-1:0] b_i;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic                 ovf;
  } sat_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 ovf;
    logic                 dz;
  } res_t;

  typedef struct packed {
    logic [RQ_AW:0] inflight;
    logic [RQ_AW:0] count;
  } stat_t;

  localparam logic signed [SW-1:0] SMAX = SW'((2 ** (DW - 1)) - 1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic [QW-1:0] QHALF = QW'(1) << (DW - 1);

  function automatic sat_t sat_s(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > SMAX) begin
      r.val = SMAX[DW-1:0];
      r.ovf = 1'b1;
    end else if (v < SMIN) begin
      r.val = SMIN[DW-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t sat_q(input logic neg, input logic big,
                                 input logic [QW-1:0] q);
    sat_t r;
    logic [QW-1:0] nq;
    nq = QW'(0) - q;
    if (neg) begin
      if (big || q > QHALF) begin
        r.val = SMIN[DW-1:0];
        r.ovf = 1'b1;
      end else begin
        r.val = nq[DW-1:0];
        r.ovf = 1'b0;
      end
    end else begin
      if (big || q > QHALF - QW'(1)) begin
        r.val = SMAX[DW-1:0];
        r.ovf = 1'b1;
      end else begin
        r.val = q[DW-1:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction
endpackage

/* hdl/complex_number_alu_core.sv */
// Complex ALU top level: add, subtract, multiply and divide on signed Q8.8
// complex operands. Depends on cna_pkg, cna_front, cna_back, assert_macros.svh.
//
// One transaction enters per cycle while full is low, and one result leaves
// per cycle while pop is high and empty is low. Every operation runs through
// the same back-end pipeline (products, combine, divider setup, one quotient
// bit per stage of a 17-bit restoring divider, final select into the result
// queue).
// A 4-entry queue separates the front end from the back end and a 32-entry
// result queue with credit issue absorbs stalls on pop.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_number_alu_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    mode,
  input  logic signed [cna_pkg::DW-1:0] a_real,
  input  logic signed [cna_pkg::DW-1:0] a_imag,
  input  logic signed [cna_pkg::DW-1:0] b_real,
  input  logic signed [cna_pkg::DW-1:0] b_imag,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [cna_pkg::DW-1:0] res_real,
  output logic signed [cna_pkg::DW-1:0] res_imag,
  output logic                          overflow,
  output logic                          div_by_zero
);
  import cna_pkg::*;

  logic  mid_valid;
  logic  mid_pop;
  item_t mid_item;
  stat_t stat;

  cna_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .a_real    (a_real),
    .a_imag    (a_imag),
    .b_real    (b_real),
    .b_imag    (b_imag),
    .mid_valid (mid_valid),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop)
  );

  cna_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_valid   (mid_valid),
    .mid_item    (mid_item),
    .mid_pop     (mid_pop),
    .empty       (empty),
    .pop         (pop),
    .res_real    (res_real),
    .res_imag    (res_imag),
    .overflow    (overflow),
    .div_by_zero (div_by_zero),
    .stat        (stat)
  );

  `CNA_ASSERT_IMP(a_dz_zero, clk, rst, !empty && div_by_zero, res_real == 0 && res_imag == 0 && !overflow)
  `CNA_ASSERT_IMP(a_credit, clk, rst, 1'b1, ({1'b0, stat.inflight} + {1'b0, stat.count}) <= RQ_DEPTH)
  `CNA_ASSERT_IMP(a_issue, clk, rst, mid_pop, mid_valid)
  `CNA_ASSERT_NXT(a_track, clk, rst, mid_pop, stat.inflight != 0)
endmodule

/* hdl/cna_front.sv */
// Front end of the complex ALU: accepts transactions, decodes the operation
// and holds them in a short queue for the back end. Uses cna_pkg.
`timescale 1ns / 1ps
module cna_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    mode,
  input  logic signed [cna_pkg::DW-1:0] a_real,
  input  logic signed [cna_pkg::DW-1:0] a_imag,
  input  logic signed [cna_pkg::DW-1:0] b_real,
  input  logic signed [cna_pkg::DW-1:0] b_imag,
  output logic                          mid_valid,
  output cna_pkg::item_t                mid_item,
  input  logic                          mid_pop
);
  import cna_pkg::*;

  item_t            mem [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr;
  logic [MQ_AW-1:0] rd_ptr;
  logic [MQ_AW:0]   count;
  logic             wr;
  logic             rd;
  item_t            item;

  assign full      = (count == (MQ_AW+1)'(MQ_DEPTH));
  assign mid_valid = (count != '0);
  assign wr        = push && !full;
  assign rd        = mid_pop && mid_valid;
  assign mid_item  = mem[rd_ptr];

  always_comb begin
    case (mode)
      2'd0:    item.op = OP_ADD;
      2'd1:    item.op = OP_SUB;
      2'd2:    item.op = OP_MUL;
      default: item.op = OP_DIV;
    endcase
    item.a_r = a_real;
    item.a_i = a_imag;
    item.b_r = b_real;
    item.b_i = b_imag;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + MQ_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + MQ_AW'(1);
      end
      count <= count + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
    end
  end
endmodule

/* hdl/cna_back.sv */
// Back end of the complex ALU: product stage, combine stage, pipelined
// restoring divider and the result queue with credit-based issue. Uses cna_pkg.
`timescale 1ns / 1ps
module cna_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mid_valid,
  input  cna_pkg::item_t                mid_item,
  output logic                          mid_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [cna_pkg::DW-1:0] res_real,
  output logic signed [cna_pkg::DW-1:0] res_imag,
  output logic                          overflow,
  output logic                          div_by_zero,
  output cna_pkg::stat_t                stat
);
  import cna_pkg::*;

  typedef struct packed {
    op_t                  op;
    logic signed [PW-1:0] p_ac;
    logic signed [PW-1:0] p_bd;
    logic signed [PW-1:0] p_ad;
    logic signed [PW-1:0] p_bc;
    logic signed [PW-1:0] p_cc;
    logic signed [PW-1:0] p_dd;
    logic signed [DW:0]   sum_r;
    logic signed [DW:0]   sum_i;
  } s0_t;

  typedef struct packed {
    op_t           op;
    sat_t          sr;
    sat_t          si;
    logic          neg_r;
    logic          neg_i;
    logic [RW-1:0] rem_r;
    logic [RW-1:0] rem_i;
    logic [NW-1:0] den;
    logic [QW-1:0] q_r;
    logic [QW-1:0] q_i;
    logic          big_r;
    logic          big_i;
    logic          dz;
  } dv_t;

  s0_t  s0, s0_n;
  logic v0;
  dv_t  d [QW+1];
  dv_t  d0_n;
  logic dv [QW+1];
  logic v1;
  dv_t  s1;

  logic                 issue;
  logic [RQ_AW:0]       inflight;
  logic [RQ_AW:0]       count;
  logic [RQ_AW-1:0]     wr_ptr;
  logic [RQ_AW-1:0]     rd_ptr;
  res_t                 rq [RQ_DEPTH];
  res_t                 fin;
  logic                 wr;
  logic                 rd;
  logic signed [SW-1:0] mr, mi, nr, ni;
  logic [SW-1:0]        ar, ai;
  dv_t                  s1_n;

  assign issue   = mid_valid && ((inflight + count) < (RQ_AW+1)'(RQ_DEPTH));
  assign mid_pop = issue;

  always_comb begin
    s0_n.op    = mid_item.op;
    s0_n.p_ac  = mid_item.a_r * mid_item.b_r;
    s0_n.p_bd  = mid_item.a_i * mid_item.b_i;
    s0_n.p_ad  = mid_item.a_r * mid_item.b_i;
    s0_n.p_bc  = mid_item.b_r * mid_item.a_i;
    s0_n.p_cc  = mid_item.b_r * mid_item.b_r;
    s0_n.p_dd  = mid_item.b_i * mid_item.b_i;
    if (mid_item.op == OP_SUB) begin
      s0_n.sum_r = (DW+1)'(mid_item.a_r) - (DW+1)'(mid_item.b_r);
      s0_n.sum_i = (DW+1)'(mid_item.a_i) - (DW+1)'(mid_item.b_i);
    end else begin
      s0_n.sum_r = (DW+1)'(mid_item.a_r) + (DW+1)'(mid_item.b_r);
      s0_n.sum_i = (DW+1)'(mid_item.a_i) + (DW+1)'(mid_item.b_i);
    end
  end

  always_comb begin
    mr = (SW'(s0.p_ac) - SW'(s0.p_bd)) >>> FB;
    mi = (SW'(s0.p_ad) + SW'(s0.p_bc)) >>> FB;
    nr = SW'(s0.p_ac) + SW'(s0.p_bd);
    ni = SW'(s0.p_bc) - SW'(s0.p_ad);
    ar = nr[SW-1] ? (SW'(0) - nr) : nr;
    ai = ni[SW-1] ? (SW'(0) - ni) : ni;
    s1_n       = '0;
    s1_n.op    = s0.op;
    s1_n.neg_r = nr[SW-1];
    s1_n.neg_i = ni[SW-1];
    s1_n.rem_r = RW'(ar[NW-1:0]);
    s1_n.rem_i = RW'(ai[NW-1:0]);
    s1_n.den   = NW'($unsigned(s0.p_cc)) + NW'($unsigned(s0.p_dd));
    s1_n.dz    = (s0.op == OP_DIV) && (s1_n.den == '0);
    case (s0.op)
      OP_ADD, OP_SUB: begin
        s1_n.sr = sat_s(SW'(s0.sum_r));
        s1_n.si = sat_s(SW'(s0.sum_i));
      end
      OP_MUL: begin
        s1_n.sr = sat_s(mr);
        s1_n.si = sat_s(mi);
      end
      default: begin
        s1_n.sr = '0;
        s1_n.si = '0;
      end
    endcase
  end

  always_comb begin
    d0_n       = s1;
    d0_n.rem_r = s1.rem_r << FB;
    d0_n.rem_i = s1.rem_i << FB;
    d0_n.big_r = CW'(d0_n.rem_r) >= (CW'(s1.den) << QW);
    d0_n.big_i = CW'(d0_n.rem_i) >= (CW'(s1.den) << QW);
    d0_n.q_r   = '0;
    d0_n.q_i   = '0;
  end

  always_ff @(posedge clk) begin
    s0   <= s0_n;
    s1   <= s1_n;
    d[0] <= d0_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      dv[0] <= 1'b0;
    end else begin
      v0    <= issue;
      v1    <= v0;
      dv[0] <= v1;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [CW-1:0] trial;
    logic          ge_r, ge_i;
    dv_t           nx;
    always_comb begin
      trial = CW'(d[j].den) << B;
      ge_r  = CW'(d[j].rem_r) >= trial;
      ge_i  = CW'(d[j].rem_i) >= trial;
      nx    = d[j];
      if (ge_r) begin
        nx.rem_r = d[j].rem_r - trial[RW-1:0];
      end
      if (ge_i) begin
        nx.rem_i = d[j].rem_i - trial[RW-1:0];
      end
      nx.q_r = {d[j].q_r[QW-2:0], ge_r};
      nx.q_i = {d[j].q_i[QW-2:0], ge_i};
    end
    always_ff @(posedge clk) begin
      d[j+1] <= nx;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end
  end

  always_comb begin
    sat_t qr, qi;
    qr = sat_q(d[QW].neg_r, d[QW].big_r, d[QW].q_r);
    qi = sat_q(d[QW].neg_i, d[QW].big_i, d[QW].q_i);
    fin = '0;
    if (d[QW].op != OP_DIV) begin
      fin.re  = d[QW].sr.val;
      fin.im  = d[QW].si.val;
      fin.ovf = d[QW].sr.ovf || d[QW].si.ovf;
    end else if (d[QW].dz) begin
      fin.dz = 1'b1;
    end else begin
      fin.re  = qr.val;
      fin.im  = qi.val;
      fin.ovf = qr.ovf || qi.ovf;
    end
  end

  assign wr          = dv[QW];
  assign empty       = (count == '0);
  assign rd          = pop && !empty;
  assign res_real    = rq[rd_ptr].re;
  assign res_imag    = rq[rd_ptr].im;
  assign overflow    = rq[rd_ptr].ovf;
  assign div_by_zero = rq[rd_ptr].dz;
  assign stat.inflight = inflight;
  assign stat.count    = count;

  always_ff @(posedge clk) begin
    if (wr) begin
      rq[wr_ptr] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      inflight <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + RQ_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + RQ_AW'(1);
      end
      count    <= count + (RQ_AW+1)'(wr) - (RQ_AW+1)'(rd);
      inflight <= inflight + (RQ_AW+1)'(issue) - (RQ_AW+1)'(wr);
    end
  end
endmodule
